### src/plain_substring_search_top_assert.svh
// Assertion macros shared by the search block.
// Each use expands to one labelled concurrent assertion on the rising clock,
// switched off while the synchronous active-low reset is asserted.
`ifndef PLAIN_SUBSTRING_SEARCH_TOP_ASSERT_SVH
`define PLAIN_SUBSTRING_SEARCH_TOP_ASSERT_SVH

// Check cons in the same cycle as ante.
`define PSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define PSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/pss_pkg.sv
`timescale 1ns / 1ps

package pss_pkg;

    // Fixed field widths
    localparam int POS_FIELD_W = 25;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int LEN_W       = 5;
    localparam int FLAG_W      = 4;
    localparam int PAT_BYTES   = 16;

    localparam logic [POS_FIELD_W-1:0] RANGE_END_RST = 25'h1000000;
    localparam logic [7:0]             WORD_UNDERSCORE = 8'h5F;

    // Bit positions in search_flags
    localparam int FLAG_CASE = 0;
    localparam int FLAG_WORD = 1;
    localparam int FLAG_BACK = 2;
    localparam int FLAG_WRAP = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW    = 3'd0,
        CFG_PATTERN_HIGH   = 3'd1,
        CFG_PATTERN_LENGTH = 3'd2,
        CFG_SEARCH_FLAGS   = 3'd3,
        CFG_START_OFFSET   = 3'd4,
        CFG_RANGE_START    = 3'd5,
        CFG_RANGE_END      = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_INVALID   = 2'd2
    } t_status;

    // Region that a candidate match falls in
    typedef struct packed {
        logic low;
        logic high;
    } t_region_sel;

    // How the final report is chosen
    typedef struct packed {
        logic backward;
        logic wrap;
        logic len_ok;
    } t_report_mode;

    // Fold ASCII upper case to lower case
    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[8'h41:8'h5A]}) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    // Letters, digits and underscore
    function automatic logic is_word(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], WORD_UNDERSCORE});
    endfunction

    // Pattern byte by index; bytes beyond the stored sixteen read as zero
    function automatic logic [7:0] pat_byte(input logic [8*PAT_BYTES-1:0] pat,
                                            input logic [5:0] idx);
        logic [7:0] r;
        r = 8'h00;
        if (idx < 6'(PAT_BYTES)) begin
            r = pat[{idx[3:0], 3'b000} +: 8];
        end
        return r;
    endfunction

endpackage

### src/pss_in_if.sv
`timescale 1ns / 1ps

interface pss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

### src/pss_out_if.sv
`timescale 1ns / 1ps

interface pss_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [24:0] match_start;
    logic [24:0] match_end;

    modport source (output valid, output status, output match_start, output match_end,
                    input ready);
    modport sink   (input valid, input status, input match_start, input match_end,
                    output ready);
endinterface

### src/pss_cell.sv
`timescale 1ns / 1ps

module pss_cell import pss_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_pat,
    input  logic       i_active,
    input  logic       i_case_sens,
    output logic [7:0] o_byte,
    output logic       o_ok
);

    logic [7:0] r_byte;

    // Take the neighbour's byte on every accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else if (i_en) begin
            r_byte <= i_byte;
        end
    end

    // Compare the byte entering this place of the window
    assign o_ok = !i_active ||
                  (i_case_sens ? (i_byte == i_pat) : (fold(i_byte) == fold(i_pat)));

    assign o_byte = r_byte;

endmodule

### src/pss_region.sv
`timescale 1ns / 1ps

module pss_region import pss_pkg::*; #(
    parameter int PW = 25
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_last,
    input  t_region_sel            i_req0,
    input  logic [PW-1:0]          i_start0,
    input  t_region_sel            i_req1,
    input  logic [PW-1:0]          i_start1,
    input  t_report_mode           i_mode,
    input  logic [LEN_W-1:0]       i_len,
    output t_status                o_status,
    output logic [POS_FIELD_W-1:0] o_match_start,
    output logic [POS_FIELD_W-1:0] o_match_end
);

    localparam int EW = (PW + 1 > POS_FIELD_W) ? PW + 1 : POS_FIELD_W;

    logic          r_found_lo, r_found_hi;
    logic [PW-1:0] r_first_lo, r_last_lo, r_first_hi, r_last_hi;
    logic          n_found_lo, n_found_hi;
    logic [PW-1:0] n_first_lo, n_last_lo, n_first_hi, n_last_hi;

    logic          found;
    logic [PW-1:0] ms;
    logic [EW-1:0] me;

    // Apply the earlier request, then the later one
    always_comb begin
        n_found_lo = r_found_lo;
        n_found_hi = r_found_hi;
        n_first_lo = r_first_lo;
        n_last_lo  = r_last_lo;
        n_first_hi = r_first_hi;
        n_last_hi  = r_last_hi;
        if (i_req0.low) begin
            if (!n_found_lo) n_first_lo = i_start0;
            n_last_lo  = i_start0;
            n_found_lo = 1'b1;
        end else if (i_req0.high) begin
            if (!n_found_hi) n_first_hi = i_start0;
            n_last_hi  = i_start0;
            n_found_hi = 1'b1;
        end
        if (i_req1.low) begin
            if (!n_found_lo) n_first_lo = i_start1;
            n_last_lo  = i_start1;
            n_found_lo = 1'b1;
        end else if (i_req1.high) begin
            if (!n_found_hi) n_first_hi = i_start1;
            n_last_hi  = i_start1;
            n_found_hi = 1'b1;
        end
    end

    // Pick the reported match
    always_comb begin
        found    = 1'b0;
        ms       = '0;
        o_status = ST_NOT_FOUND;
        if (!i_mode.len_ok) begin
            o_status = ST_INVALID;
        end else if (!i_mode.backward) begin
            if (n_found_hi) begin
                ms    = n_first_hi;
                found = 1'b1;
            end else if (i_mode.wrap && n_found_lo) begin
                ms    = n_first_lo;
                found = 1'b1;
            end
        end else begin
            if (n_found_lo) begin
                ms    = n_last_lo;
                found = 1'b1;
            end else if (i_mode.wrap && n_found_hi) begin
                ms    = n_last_hi;
                found = 1'b1;
            end
        end
        if (found) begin
            o_status = ST_FOUND;
        end
    end

    assign me            = EW'(ms) + EW'(i_len);
    assign o_match_start = found ? POS_FIELD_W'(EW'(ms)) : '0;
    assign o_match_end   = found ? me[POS_FIELD_W-1:0] : '0;

    // Hold the region bookkeeping; drop it after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found_lo <= 1'b0;
            r_found_hi <= 1'b0;
        end else if (i_en) begin
            r_found_lo <= i_last ? 1'b0 : n_found_lo;
            r_found_hi <= i_last ? 1'b0 : n_found_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_first_lo <= n_first_lo;
            r_last_lo  <= n_last_lo;
            r_first_hi <= n_first_hi;
            r_last_hi  <= n_last_hi;
        end
    end

endmodule

### src/plain_substring_search_top.sv
// Streaming fixed-pattern search over a document.
// Input channel i_doc carries one document byte per word, the final byte of
// a document marked by last_byte. Output channel o_res carries one word per
// document: status (found, not found, invalid length) and the match bounds.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data; the
// user writes it between documents, which the block itself does not enforce.
// Throughput: one byte per cycle. The window compare is a row of cells, one
// per pattern position, each comparing the byte it takes in that cycle.
// A result word passes the input register, the compare stage and the region
// update into the output register.
// When o_res stalls, bytes keep flowing; input is held only while the next
// document's last byte reaches the region stage and the previous result is
// still untaken.
// Reset clears the window, position, pending candidate and region flags at
// once and sets the registers to their defaults; there is no clearing pass.
`timescale 1ns / 1ps
`include "plain_substring_search_top_assert.svh"

module plain_substring_search_top import pss_pkg::*; #(
    parameter int PATTERN_MAX   = 16,
    parameter int POSITION_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pss_in_if.sink               i_doc,
    pss_out_if.source            o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int PW    = POSITION_BITS + 1;
    localparam int DEPTH = PATTERN_MAX + 1;
    localparam int CW    = (PW > POS_FIELD_W) ? PW : POS_FIELD_W;
    localparam logic [PW-1:0] POS_LIMIT = {1'b1, {POSITION_BITS{1'b0}}};

    // Configuration registers
    logic [CFG_W-1:0]       r_pat_lo, r_pat_hi;
    logic [LEN_W-1:0]       r_len;
    logic [FLAG_W-1:0]      r_flags;
    logic [POS_FIELD_W-1:0] r_start_off, r_range_a, r_range_b;

    // Ordered range and clamped start
    logic [POS_FIELD_W-1:0] n_lo, n_hi, n_st, r_lo, r_hi, r_st;

    // Pipeline
    logic                   adv, stall, fire_a, fire_b;
    logic                   r_a_valid, r_a_last;
    logic [7:0]             r_a_byte;
    logic                   r_b_valid, r_b_last;
    t_region_sel            r_b_req0, r_b_req1;
    logic [PW-1:0]          r_b_start0, r_b_start1;

    // Document state
    logic [PW-1:0]          r_pos;
    logic                   r_pend_valid;
    logic [PW-1:0]          r_pend_start;
    t_region_sel            r_pend_sel;

    // Window cells
    logic [7:0]             w_d [DEPTH];
    logic [7:0]             w_q [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] w_ok;

    // Compare stage
    logic                   len_ok, in_range, enough, hit, word_ok, set_pend;
    logic [PW-1:0]          pos_nx, len_p, cand_start;
    logic [7:0]             prev_byte;
    t_region_sel            sel_cand, req0, req1;
    t_report_mode           mode;

    // Region stage and output register
    t_status                res_status;
    logic [POS_FIELD_W-1:0] res_start, res_end;
    logic                   r_out_valid;
    t_status                r_out_status;
    logic [POS_FIELD_W-1:0] r_out_start, r_out_end;

    // Write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo    <= '0;
            r_pat_hi    <= '0;
            r_len       <= '0;
            r_flags     <= '0;
            r_start_off <= '0;
            r_range_a   <= '0;
            r_range_b   <= RANGE_END_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PATTERN_LOW:    r_pat_lo    <= i_cfg_data;
                CFG_PATTERN_HIGH:   r_pat_hi    <= i_cfg_data;
                CFG_PATTERN_LENGTH: r_len       <= i_cfg_data[LEN_W-1:0];
                CFG_SEARCH_FLAGS:   r_flags     <= i_cfg_data[FLAG_W-1:0];
                CFG_START_OFFSET:   r_start_off <= i_cfg_data[POS_FIELD_W-1:0];
                CFG_RANGE_START:    r_range_a   <= i_cfg_data[POS_FIELD_W-1:0];
                CFG_RANGE_END:      r_range_b   <= i_cfg_data[POS_FIELD_W-1:0];
                default: ;
            endcase
        end
    end

    // Order the range ends and clamp the start
    always_comb begin
        n_lo = (r_range_a < r_range_b) ? r_range_a : r_range_b;
        n_hi = (r_range_a < r_range_b) ? r_range_b : r_range_a;
        n_st = r_start_off;
        if (n_st < n_lo) n_st = n_lo;
        if (n_st > n_hi) n_st = n_hi;
    end

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;
        r_hi <= n_hi;
        r_st <= n_st;
    end

    // Handshake: hold everything only when a result meets a full output
    assign stall       = r_b_valid && r_b_last && r_out_valid && !o_res.ready;
    assign adv         = !stall;
    assign fire_a      = r_a_valid && adv;
    assign fire_b      = r_b_valid && adv;
    assign i_doc.ready = adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= i_doc.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_byte <= i_doc.text_byte;
            r_a_last <= i_doc.last_byte;
        end
    end

    // Row of window cells; cell k sees the byte k places back
    assign w_d[0] = r_a_byte;

    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        localparam logic [5:0] KI = 6'(k);
        logic [5:0] pat_idx;

        assign pat_idx    = {1'b0, r_len} - KI - 6'd1;
        assign w_d[k + 1] = w_q[k];

        pss_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (fire_a),
            .i_byte      (w_d[k]),
            .i_pat       (pat_byte({r_pat_hi, r_pat_lo}, pat_idx)),
            .i_active    (KI < {1'b0, r_len}),
            .i_case_sens (r_flags[FLAG_CASE]),
            .o_byte      (w_q[k]),
            .o_ok        (w_ok[k])
        );
    end

    // Byte just ahead of a candidate
    always_comb begin
        prev_byte = 8'h00;
        for (int k = 0; k < DEPTH; k++) begin
            if (6'(k) == {1'b0, r_len}) prev_byte = w_d[k];
        end
    end

    // Candidate detection and region class
    always_comb begin
        len_ok     = (r_len != '0) && ({1'b0, r_len} <= 6'(PATTERN_MAX));
        in_range   = !r_pos[PW-1];
        pos_nx     = r_pos + PW'(1);
        len_p      = PW'(r_len);
        enough     = pos_nx >= len_p;
        cand_start = pos_nx - len_p;
        sel_cand.low  = (CW'(cand_start) >= CW'(r_lo)) && (CW'(pos_nx) <= CW'(r_st));
        sel_cand.high = (CW'(cand_start) >= CW'(r_st)) && (CW'(pos_nx) <= CW'(r_hi));
        hit        = len_ok && in_range && enough && (&w_ok);
        word_ok    = (cand_start == '0) || !is_word(prev_byte);
        req1       = '0;
        if (hit && (!r_flags[FLAG_WORD] || (word_ok && r_a_last))) begin
            req1 = sel_cand;
        end
        set_pend   = hit && r_flags[FLAG_WORD] && word_ok && !r_a_last;
        req0       = '0;
        if (r_pend_valid && !is_word(r_a_byte)) begin
            req0 = r_pend_sel;
        end
    end

    // Advance position and pending candidate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_pend_valid <= 1'b0;
        end else if (fire_a) begin
            if (r_a_last) begin
                r_pos <= '0;
            end else if (in_range) begin
                r_pos <= pos_nx;
            end
            r_pend_valid <= set_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_a && set_pend) begin
            r_pend_start <= cand_start;
            r_pend_sel   <= sel_cand;
        end
    end

    // Compare stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_last   <= r_a_last;
            r_b_req0   <= req0;
            r_b_start0 <= r_pend_start;
            r_b_req1   <= req1;
            r_b_start1 <= cand_start;
        end
    end

    // Region bookkeeping and report selection
    assign mode = '{backward: r_flags[FLAG_BACK], wrap: r_flags[FLAG_WRAP], len_ok: len_ok};

    pss_region #(.PW(PW)) u_region (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (fire_b),
        .i_last        (r_b_last),
        .i_req0        (r_b_req0),
        .i_start0      (r_b_start0),
        .i_req1        (r_b_req1),
        .i_start1      (r_b_start1),
        .i_mode        (mode),
        .i_len         (r_len),
        .o_status      (res_status),
        .o_match_start (res_start),
        .o_match_end   (res_end)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire_b && r_b_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_b && r_b_last) begin
            r_out_status <= res_status;
            r_out_start  <= res_start;
            r_out_end    <= res_end;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_status;
    assign o_res.match_start = r_out_start;
    assign o_res.match_end   = r_out_end;

    `PSS_ASSERT_NOW(a_pos_bound, i_clk, i_rst_n, 1'b1, r_pos <= POS_LIMIT, "position past limit")
    `PSS_ASSERT_NEXT(a_doc_restart, i_clk, i_rst_n, fire_a && r_a_last, (r_pos == '0) && !r_pend_valid, "state not cleared after last byte")
    `PSS_ASSERT_NEXT(a_hold_result, i_clk, i_rst_n, stall, r_b_valid && r_b_last && r_out_valid, "result lost while blocked")
    `PSS_ASSERT_NOW(a_found_span, i_clk, i_rst_n, r_out_valid && (r_out_status == ST_FOUND), (r_out_end - r_out_start) == POS_FIELD_W'(r_len), "match span differs from length")
    `PSS_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, r_out_valid && (r_out_status != ST_FOUND), (r_out_start == '0) && (r_out_end == '0), "bounds set without a match")

endmodule

### tb/sv/plain_substring_search_top_test.sv
`timescale 1ns / 1ps

module plain_substring_search_top_test;
    import pss_pkg::*;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          SETTLE       = 4;
    localparam int          GAP_CAP      = 40;
    localparam logic [24:0] POS_SATURATE = 25'h1000000;

    localparam logic [3:0] SENSITIVE  = 4'(1 << FLAG_CASE);
    localparam logic [3:0] WHOLE_WORD = 4'(1 << FLAG_WORD);
    localparam logic [3:0] BACKWARD   = 4'(1 << FLAG_BACK);
    localparam logic [3:0] WRAP       = 4'(1 << FLAG_WRAP);

    typedef struct {
        t_status     status;
        logic [24:0] match_start;
        logic [24:0] match_end;
    } t_search_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    pss_in_if  doc_if ();
    pss_out_if res_if ();

    plain_substring_search_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_doc       (doc_if),
        .o_res       (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Register copies as the block holds them
    logic [63:0] set_pat_lo;
    logic [63:0] set_pat_hi;
    logic [4:0]  set_len;
    logic [3:0]  set_flags;
    logic [24:0] set_start;
    logic [24:0] set_range_a;
    logic [24:0] set_range_b;

    // Per-document search state
    logic [7:0]  text_window [0:PAT_BYTES];
    logic [24:0] doc_pos;
    logic        pending_ok;
    logic [24:0] pending_at;
    logic [24:0] low_first;
    logic [24:0] low_last;
    logic [24:0] high_first;
    logic [24:0] high_last;
    logic [3:0]  region_hits;

    t_search_result expected_results [$];

    int fail_count;
    int bytes_sent;
    int documents_sent;
    int results_compared;
    int cycle_count;
    int tx_idle_pct;
    int rx_idle_pct;
    int long_stall_left;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Search prediction
    // ------------------------------------------------------------------

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function automatic logic [7:0] swap_case(input logic [7:0] c);
        logic [7:0] l;
        l = c | 8'h20;
        return (l >= 8'h61 && l <= 8'h7A) ? c ^ 8'h20 : c;
    endfunction

    function automatic logic word_char(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A) || c == WORD_UNDERSCORE;
    endfunction

    function automatic logic [7:0] pattern_byte(input int i);
        if (i < 8) begin
            return set_pat_lo[8*i +: 8];
        end
        if (i < PAT_BYTES) begin
            return set_pat_hi[8*(i-8) +: 8];
        end
        return 8'h00;
    endfunction

    function automatic logic length_valid();
        return set_len >= 5'd1 && set_len <= 5'(PAT_BYTES);
    endfunction

    function automatic void clear_document();
        for (int i = 0; i <= PAT_BYTES; i++) begin
            text_window[i] = 8'h00;
        end
        doc_pos     = '0;
        pending_ok  = 1'b0;
        pending_at  = '0;
        low_first   = '0;
        low_last    = '0;
        high_first  = '0;
        high_last   = '0;
        region_hits = '0;
    endfunction

    // Record a candidate in the region that wholly contains it
    function automatic void note_candidate(input logic [24:0] s);
        logic [24:0] lo_end;
        logic [24:0] hi_end;
        logic [24:0] split;
        logic [25:0] e;
        lo_end = (set_range_a < set_range_b) ? set_range_a : set_range_b;
        hi_end = (set_range_a < set_range_b) ? set_range_b : set_range_a;
        split  = set_start;
        if (split < lo_end) split = lo_end;
        if (split > hi_end) split = hi_end;
        e = {1'b0, s} + set_len;
        if (s >= lo_end && e <= split) begin
            if (!region_hits[0]) low_first = s;
            low_last    = s;
            region_hits = region_hits | 4'b0011;
        end else if (s >= split && e <= hi_end) begin
            if (!region_hits[2]) high_first = s;
            high_last   = s;
            region_hits = region_hits | 4'b1100;
        end
    endfunction

    // Advance the search by one document byte; returns 1 when a result is due
    function automatic bit search_step(input logic [7:0] c, input logic is_last,
                                       output t_search_result r);
        logic [24:0] p;
        logic [24:0] s;
        logic [24:0] ms;
        logic [7:0]  t;
        logic [7:0]  q;
        logic        hit;
        logic        found;
        int          plen;
        int          i;
        p    = doc_pos;
        plen = set_len;
        r.status      = ST_NOT_FOUND;
        r.match_start = '0;
        r.match_end   = '0;

        // A pending whole-word candidate is settled by the byte after it
        if (pending_ok) begin
            pending_ok = 1'b0;
            if (!word_char(c)) note_candidate(pending_at);
        end

        for (i = PAT_BYTES; i > 0; i--) begin
            text_window[i] = text_window[i-1];
        end
        text_window[0] = c;

        if (length_valid() && p < POS_SATURATE && {1'b0, p} + 26'd1 >= plen) begin
            hit = 1'b1;
            for (i = 0; i < plen; i++) begin
                t = text_window[plen-1-i];
                q = pattern_byte(i);
                if (set_flags[FLAG_CASE] ? (t != q) : (lower_ascii(t) != lower_ascii(q))) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                s = p + 25'd1 - 25'(plen);
                if (!set_flags[FLAG_WORD]) begin
                    note_candidate(s);
                end else if (s == '0 || !word_char(text_window[plen])) begin
                    if (is_last) begin
                        note_candidate(s);
                    end else begin
                        pending_ok = 1'b1;
                        pending_at = s;
                    end
                end
            end
        end

        if (p < POS_SATURATE) doc_pos = p + 25'd1;
        if (!is_last) return 0;

        // Pick the reported match by direction and wrap
        found = 1'b0;
        ms    = '0;
        if (!length_valid()) begin
            r.status = ST_INVALID;
        end else if (!set_flags[FLAG_BACK]) begin
            if (region_hits[2]) begin
                ms = high_first;
                found = 1'b1;
            end else if (set_flags[FLAG_WRAP] && region_hits[0]) begin
                ms = low_first;
                found = 1'b1;
            end
        end else begin
            if (region_hits[1]) begin
                ms = low_last;
                found = 1'b1;
            end else if (set_flags[FLAG_WRAP] && region_hits[3]) begin
                ms = high_last;
                found = 1'b1;
            end
        end
        if (found) begin
            r.status      = ST_FOUND;
            r.match_start = ms;
            r.match_end   = ms + 25'(set_len);
        end
        clear_document();
        return 1;
    endfunction

    // ------------------------------------------------------------------
    // Monitors
    // ------------------------------------------------------------------

    // Predict on each accepted byte, compare each accepted result word
    always @(posedge i_clk) begin : result_monitor
        t_search_result predicted;
        t_search_result want;
        if (i_rst_n) begin
            if (doc_if.valid && doc_if.ready) begin
                if (doc_if.last_byte) documents_sent++;
                if (search_step(doc_if.text_byte, doc_if.last_byte, predicted)) begin
                    expected_results.push_back(predicted);
                end
            end
            if (res_if.valid && res_if.ready) begin
                results_compared++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result word status %0d start %0d end %0d",
                             $time, res_if.status, res_if.match_start, res_if.match_end);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (res_if.status !== want.status ||
                        res_if.match_start !== want.match_start ||
                        res_if.match_end !== want.match_end) begin
                        $display("%0t: mismatch expected status %0d start %0d end %0d, %s %0d %0d %0d",
                                 $time, want.status, want.match_start, want.match_end,
                                 "actual", res_if.status, res_if.match_start,
                                 res_if.match_end);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Receiver: hold off for a long stall when asked, else stall at random
    always @(posedge i_clk) begin
        if (long_stall_left > 0) begin
            res_if.ready <= 1'b0;
            long_stall_left--;
        end else begin
            res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Write one register and update the local copy at the write edge
    task automatic write_register(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            CFG_PATTERN_LOW:    set_pat_lo  = value;
            CFG_PATTERN_HIGH:   set_pat_hi  = value;
            CFG_PATTERN_LENGTH: set_len     = value[4:0];
            CFG_SEARCH_FLAGS:   set_flags   = value[3:0];
            CFG_START_OFFSET:   set_start   = value[24:0];
            CFG_RANGE_START:    set_range_a = value[24:0];
            CFG_RANGE_END:      set_range_b = value[24:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [63:0] lo, input logic [63:0] hi,
                                 input logic [4:0] len, input logic [3:0] flags,
                                 input logic [24:0] start, input logic [24:0] ra,
                                 input logic [24:0] rb);
        write_register(CFG_PATTERN_LOW, lo);
        write_register(CFG_PATTERN_HIGH, hi);
        write_register(CFG_PATTERN_LENGTH, 64'(len));
        write_register(CFG_SEARCH_FLAGS, 64'(flags));
        write_register(CFG_START_OFFSET, 64'(start));
        write_register(CFG_RANGE_START, 64'(ra));
        write_register(CFG_RANGE_END, 64'(rb));
        cfg_we <= 1'b0;
    endtask

    // Offer one byte word, with a random gap first; valid stays high after
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        gap = 0;
        while (gap < GAP_CAP && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            doc_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        doc_if.valid     <= 1'b1;
        doc_if.text_byte <= b;
        doc_if.last_byte <= is_last;
        @(posedge i_clk);
        while (!doc_if.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Drop valid and hold until every result word has been taken
    task automatic await_results(input int settle);
        doc_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_text_char();
        case ($urandom_range(11))
            0, 1:    return 8'h61;
            2:       return 8'h62;
            3:       return 8'h41;
            4:       return 8'h42;
            5:       return WORD_UNDERSCORE;
            6:       return 8'h20;
            7:       return 8'h2D;
            8:       return 8'h30;
            9:       return 8'h7A;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [24:0] pick_bound();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0:       return 25'd0;
            1:       return POS_SATURATE;
            2:       return r[24:0];
            default: return 25'($urandom_range(24));
        endcase
    endfunction

    // Document of mostly pattern copies with random case and the odd corrupt byte
    task automatic send_random_document();
        logic [7:0] text [$];
        logic [7:0] b;
        int         target_len;
        int         plen;
        int         i;
        target_len = ($urandom_range(99) < 85) ? $urandom_range(1, 20) : $urandom_range(21, 60);
        plen = (set_len > 5'(PAT_BYTES)) ? PAT_BYTES : set_len;
        while (text.size() < target_len) begin
            if (plen != 0 && $urandom_range(2) == 0) begin
                for (i = 0; i < plen; i++) begin
                    b = pattern_byte(i);
                    if ($urandom_range(3) == 0) b = swap_case(b);
                    if ($urandom_range(29) == 0) b = pick_text_char();
                    text.push_back(b);
                end
            end else begin
                text.push_back(pick_text_char());
            end
        end
        foreach (text[k]) begin
            send_byte(text[k], k == text.size() - 1);
        end
    endtask

    task automatic randomize_settings();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  len;
        int          r;
        int          i;
        for (i = 0; i < 8; i++) begin
            lo[8*i +: 8] = pick_text_char();
            hi[8*i +: 8] = pick_text_char();
        end
        if ($urandom_range(9) == 0) begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
        end
        r = $urandom_range(99);
        if (r < 4) len = 5'd0;
        else if (r < 8) len = 5'($urandom_range(17, 31));
        else if (r < 16) len = 5'(PAT_BYTES);
        else len = 5'($urandom_range(1, 5));
        load_settings(lo, hi, len, 4'($urandom_range(15)), pick_bound(), pick_bound(),
                      pick_bound());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers at reset give an empty pattern
    task automatic test_reset_defaults();
        send_byte(8'h41, 1'b1);
        await_results(SETTLE);
    endtask

    // Length above the maximum, all-ones start offset, reversed extreme range
    task automatic test_invalid_length();
        load_settings({$urandom, $urandom}, {$urandom, $urandom}, 5'd17, 4'hF,
                      25'h1FFFFFF, 25'h1FFFFFF, 25'd0);
        send_byte(8'hFF, 1'b1);
        await_results(SETTLE);
    endtask

    // Sixteen-byte pattern with extreme bytes, matched with letters in swapped case
    task automatic test_longest_pattern();
        int i;
        load_settings(64'h4142_5A61_7A5F_00FF, 64'h5B40_7F80_202D_3930, 5'(PAT_BYTES),
                      4'h0, 25'd0, 25'd0, POS_SATURATE);
        for (i = 0; i < PAT_BYTES; i++) begin
            send_byte(swap_case(pattern_byte(i)), i == PAT_BYTES - 1);
        end
        await_results(SETTLE);
    endtask

    // "aB" found in "Ab" without case sensitivity
    task automatic test_case_fold();
        load_settings(64'h4261, 64'h0, 5'd2, 4'h0, 25'd0, 25'd0, POS_SATURATE);
        send_byte(8'h41, 1'b0);
        send_byte(8'h62, 1'b1);
        await_results(SETTLE);
    endtask

    // Whole-word "ab" ending on the last byte has no following byte to check
    task automatic test_whole_word_at_end();
        load_settings(64'h6261, 64'h0, 5'd2, SENSITIVE | WHOLE_WORD, 25'd0, 25'd0,
                      POS_SATURATE);
        send_byte(8'h2D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b1);
        await_results(SETTLE);
    endtask

    // Backward search with an empty low region wraps to the high one;
    // range given reversed
    task automatic test_backward_wrap();
        load_settings(64'h6261, 64'h0, 5'd2, SENSITIVE | BACKWARD | WRAP, 25'd1, 25'd4,
                      25'd0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b1);
        await_results(SETTLE);
    endtask

    // Long output stall while documents keep coming, so the input backs up
    task automatic test_output_stall();
        int saved_tx;
        saved_tx = tx_idle_pct;
        tx_idle_pct = 0;
        load_settings(64'h6261, 64'h0, 5'd2, SENSITIVE | WRAP, 25'd0, 25'd0, POS_SATURATE);
        long_stall_left = 300;
        repeat (8) send_random_document();
        await_results(SETTLE);
        tx_idle_pct = saved_tx;
    endtask

    // Random phases: new settings, a few documents, sometimes a sender pause
    task automatic test_random_documents(input int byte_target);
        int n;
        while (bytes_sent < byte_target) begin
            randomize_settings();
            n = $urandom_range(1, 4);
            repeat (n) begin
                send_random_document();
                if ($urandom_range(4) == 0) await_results(0);
            end
            await_results(SETTLE);
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        doc_if.valid     = 1'b0;
        doc_if.text_byte = 8'h00;
        doc_if.last_byte = 1'b0;
        res_if.ready     = 1'b0;
        fail_count       = 0;
        bytes_sent       = 0;
        documents_sent   = 0;
        results_compared = 0;
        cycle_count      = 0;
        long_stall_left  = 0;
        tx_idle_pct      = 6;
        rx_idle_pct      = 84;
        set_pat_lo       = '0;
        set_pat_hi       = '0;
        set_len          = '0;
        set_flags        = '0;
        set_start        = '0;
        set_range_a      = '0;
        set_range_b      = RANGE_END_RST;
        clear_document();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_invalid_length();
        test_longest_pattern();
        test_case_fold();
        test_whole_word_at_end();
        test_backward_wrap();
        test_random_documents(400);
        test_output_stall();

        tx_idle_pct = 84;
        rx_idle_pct = 6;
        test_random_documents(730);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_documents(1060);

        await_results(SETTLE);
        $display("Covered %0d bytes in %0d documents, %0d result words compared, %0d failures",
                 bytes_sent, documents_sent, results_compared, fail_count);
        $display("Pattern lengths 0 to 31, random flags and ranges, long output stall, pauses");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
